@@ src/ntc_raw_to_temperature_top_macros.svh @@
// Assertion macros shared by the converter modules.
`ifndef NTC_RAW_TO_TEMPERATURE_TOP_MACROS_SVH
`define NTC_RAW_TO_TEMPERATURE_TOP_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define NTCRT_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ntcrt assertion failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define NTCRT_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ntcrt assertion failed");

`endif

@@ src/ntcrt_pkg.sv @@
`default_nettype none

package ntcrt_pkg;

  localparam int NTC_POINTS = 33;
  localparam int S_W = 16;  // raw sample
  localparam int T_W = 11;  // table temperature, signed
  localparam int D_W = 15;  // segment offset and span
  localparam int Q_W = 10;  // interpolation step, at most 575
  localparam int N_W = D_W + Q_W;
  localparam int O_W = 16;  // result temperature

  localparam logic signed [O_W-1:0] OVER_TEMP = 16'sh8000;

  localparam logic [S_W-1:0] BREAKPOINT [NTC_POINTS] = '{
    16'h0000, 16'h4e00, 16'h5680, 16'h5fc0, 16'h6980, 16'h73c0, 16'h7e40, 16'h8940,
    16'h9440, 16'h9f40, 16'haa00, 16'hb480, 16'hbe40, 16'hc780, 16'hd000, 16'hd780,
    16'hde40, 16'he440, 16'he940, 16'hed80, 16'hf140, 16'hf440, 16'hf6c0, 16'hf8c0,
    16'hfa40, 16'hfbc0, 16'hfcc0, 16'hfd80, 16'hfe00, 16'hfe80, 16'hfec0, 16'hff00,
    16'hff40
  };

  localparam logic signed [T_W-1:0] TEMP_AT [NTC_POINTS] = '{
    11'sd700, 11'sd125, 11'sd120, 11'sd115, 11'sd110, 11'sd105, 11'sd100, 11'sd95,
    11'sd90, 11'sd85, 11'sd80, 11'sd75, 11'sd70, 11'sd65, 11'sd60, 11'sd55,
    11'sd50, 11'sd45, 11'sd40, 11'sd35, 11'sd30, 11'sd25, 11'sd20, 11'sd15,
    11'sd10, 11'sd5, 11'sd0, -11'sd5, -11'sd10, -11'sd15, -11'sd20, -11'sd25,
    -11'sd30
  };

  // One classified sample: the segment it falls in and its offset there.
  typedef struct packed {
    logic                  over;
    logic signed [T_W-1:0] prev_t;
    logic [D_W-1:0]        d;
    logic [D_W-1:0]        vr;
    logic [Q_W-1:0]        tr;
  } seg_t;

endpackage

`default_nettype wire

@@ src/ntcrt_front.sv @@
`default_nettype none

module ntcrt_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [ntcrt_pkg::S_W-1:0]  raw_sample,
  output logic                            seg_valid,
  input  wire logic                       seg_ready,
  output ntcrt_pkg::seg_t                 seg
);

  logic                                  valid;
  logic [ntcrt_pkg::S_W-1:0]             sample;
  logic [ntcrt_pkg::NTC_POINTS-1:0]      ge;
  logic [ntcrt_pkg::NTC_POINTS-1:0]      ge_next;

  assign in_stall  = valid && !seg_ready;
  assign seg_valid = valid;

  // Compare against every breakpoint up front.
  always_comb begin
    for (int i = 0; i < ntcrt_pkg::NTC_POINTS; i++) begin
      ge_next[i] = (ntcrt_pkg::BREAKPOINT[i] >= raw_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      sample <= raw_sample;
      ge     <= ge_next;
    end
  end

  // Pick the first breakpoint not below the sample; lowest index wins.
  always_comb begin
    seg        = '0;
    seg.over   = 1'b1;
    seg.vr     = ntcrt_pkg::D_W'(1);
    for (int i = ntcrt_pkg::NTC_POINTS - 1; i >= 1; i--) begin
      if (ge[i]) begin
        seg.over   = 1'b0;
        seg.prev_t = ntcrt_pkg::TEMP_AT[i-1];
        seg.d      = ntcrt_pkg::D_W'(sample - ntcrt_pkg::BREAKPOINT[i-1]);
        seg.vr     = ntcrt_pkg::D_W'(ntcrt_pkg::BREAKPOINT[i] -
                                     ntcrt_pkg::BREAKPOINT[i-1]);
        seg.tr     = ntcrt_pkg::Q_W'(ntcrt_pkg::TEMP_AT[i-1] - ntcrt_pkg::TEMP_AT[i]);
      end
    end
    // Zero sample lands on the first breakpoint exactly.
    if (ge[0]) begin
      seg.over   = 1'b0;
      seg.prev_t = ntcrt_pkg::TEMP_AT[0];
      seg.d      = '0;
      seg.vr     = ntcrt_pkg::D_W'(1);
      seg.tr     = '0;
    end
  end

endmodule

`default_nettype wire

@@ src/ntcrt_queue.sv @@
`default_nettype none

`include "ntc_raw_to_temperature_top_macros.svh"

module ntcrt_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire ntcrt_pkg::seg_t  wr_seg,
  output logic                  rd_valid,
  input  wire logic             rd_pop,
  output ntcrt_pkg::seg_t       rd_seg
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ntcrt_pkg::seg_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;
  assign rd_seg   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `NTCRT_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `NTCRT_ASSERT_NEXT(a_count_track, clk, rst, push && !pop, count == $past(count) + CW'(1))

endmodule

`default_nettype wire

@@ src/ntcrt_back.sv @@
`default_nettype none

`include "ntc_raw_to_temperature_top_macros.svh"

module ntcrt_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_pop,
  input  wire ntcrt_pkg::seg_t                    in_seg,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [ntcrt_pkg::O_W-1:0]        temperature,
  output logic                                    over_range
);

  localparam int QW = ntcrt_pkg::Q_W;
  localparam int NW = ntcrt_pkg::N_W;
  localparam int DW = ntcrt_pkg::D_W;
  localparam int TW = ntcrt_pkg::T_W;
  localparam int OW = ntcrt_pkg::O_W;

  // Stage 0 holds the product; stages 1..QW each settle one quotient bit.
  logic                 v      [QW+1];
  logic [NW-1:0]        rem    [QW+1];
  logic [QW-1:0]        quo    [QW+1];
  logic [DW-1:0]        vr     [QW+1];
  logic signed [TW-1:0] prev_t [QW+1];
  logic                 over   [QW+1];
  logic                 adv;

  // Freeze the whole pipe while a finished item is held.
  assign adv    = !out_valid || !out_stall;
  assign in_pop = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]    <= NW'(in_seg.d) * NW'(in_seg.tr);
      quo[0]    <= '0;
      vr[0]     <= in_seg.vr;
      prev_t[0] <= in_seg.prev_t;
      over[0]   <= in_seg.over;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int K = QW - j;
    logic [NW-1:0] dv;
    logic          take;

    assign dv   = NW'(vr[j-1]) << K;
    assign take = (rem[j-1] >= dv);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (adv) begin
        v[j] <= v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[j]    <= take ? rem[j-1] - dv : rem[j-1];
        quo[j]    <= take ? (quo[j-1] | (QW'(1) << K)) : quo[j-1];
        vr[j]     <= vr[j-1];
        prev_t[j] <= prev_t[j-1];
        over[j]   <= over[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      over_range  <= over[QW];
      temperature <= over[QW] ? ntcrt_pkg::OVER_TEMP :
                     OW'(signed'({{(OW-TW){prev_t[QW][TW-1]}}, prev_t[QW]}) -
                         signed'({{(OW-QW){1'b0}}, quo[QW]}));
    end
  end

  `NTCRT_ASSERT_IMPLY(a_over_code, clk, rst, out_valid && over_range, temperature == ntcrt_pkg::OVER_TEMP)
  `NTCRT_ASSERT_IMPLY(a_in_span, clk, rst, out_valid && !over_range, (temperature <= 16'sd700) && (temperature >= -16'sd30))

endmodule

`default_nettype wire

@@ src/ntc_raw_to_temperature_top.sv @@
// NTC thermistor sample to temperature converter.
// Input channel: in_valid / in_stall with raw_sample, a left-aligned 16-bit
// ADC reading. Output channel: out_valid / out_stall with temperature
// (signed whole degrees C) and over_range. A transfer happens on a rising
// clk edge with valid high and stall low; each input item yields one item.
// Throughput: one item per cycle sustained while out_stall stays low. An item
// passes the compare stage, loaded at the accepting edge, then the queue,
// 1 multiply stage, 10 divider stages and 1 output register before out_valid
// rises; the ten stage restoring divider sets the depth.
// A sample above the last breakpoint gives -32768 with over_range set; a
// sample of 0 gives 700.
// Reset (rst, synchronous, active high) empties every stage and the queue;
// no item is in flight afterward.
// When the receiver stalls, the back pipe holds its result and freezes;
// the front keeps taking items into the queue until it fills, then raises
// in_stall.
`default_nettype none

module ntc_raw_to_temperature_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ntcrt_pkg::S_W-1:0]    raw_sample,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [ntcrt_pkg::O_W-1:0]  temperature,
  output logic                              over_range
);

  // Classified items between front and back.
  logic            f_valid;
  logic            f_ready;
  ntcrt_pkg::seg_t f_seg;
  logic            q_valid;
  logic            q_pop;
  ntcrt_pkg::seg_t q_seg;

  // Front: register the sample and its breakpoint compares, pick the segment.
  ntcrt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .raw_sample (raw_sample),
    .seg_valid  (f_valid),
    .seg_ready  (f_ready),
    .seg        (f_seg)
  );

  // Queue: decouple front from a stalled back.
  ntcrt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_seg   (f_seg),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_seg   (q_seg)
  );

  // Back: multiply, divide one bit per stage, subtract from segment start.
  ntcrt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_pop      (q_pop),
    .in_seg      (q_seg),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .temperature (temperature),
    .over_range  (over_range)
  );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

// Checks the thermistor sample converter one item at a time: every accepted
// sample queues its expected temperature, and every accepted result is
// compared with the oldest one queued.
module testbench;

  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 10;
  localparam int PHASE_ITEMS  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 90;      // long enough to fill pipe and queue
  localparam int CYCLE_LIMIT  = 200000;
  localparam int KNEES        = 33;

  // Breakpoints of the conversion table and the temperature at each one.
  localparam logic [15:0] SAMPLE_KNEE [KNEES] = '{
    16'h0000, 16'h4e00, 16'h5680, 16'h5fc0, 16'h6980, 16'h73c0, 16'h7e40, 16'h8940,
    16'h9440, 16'h9f40, 16'haa00, 16'hb480, 16'hbe40, 16'hc780, 16'hd000, 16'hd780,
    16'hde40, 16'he440, 16'he940, 16'hed80, 16'hf140, 16'hf440, 16'hf6c0, 16'hf8c0,
    16'hfa40, 16'hfbc0, 16'hfcc0, 16'hfd80, 16'hfe00, 16'hfe80, 16'hfec0, 16'hff00,
    16'hff40
  };

  localparam int DEGREE_AT [KNEES] = '{
    700, 125, 120, 115, 110, 105, 100, 95,
    90, 85, 80, 75, 70, 65, 60, 55,
    50, 45, 40, 35, 30, 25, 20, 15,
    10, 5, 0, -5, -10, -15, -20, -25,
    -30
  };

  typedef struct packed {
    logic signed [ntcrt_pkg::O_W-1:0] temperature;
    logic                             over_range;
  } reading_t;

  // One directed row: when fixed is set the expected reading is typed in,
  // otherwise it comes from the predictor.
  typedef struct packed {
    logic [ntcrt_pkg::S_W-1:0]        sample;
    logic                             fixed;
    logic signed [ntcrt_pkg::O_W-1:0] temperature;
    logic                             over_range;
  } probe_t;

  localparam int PROBES = 21;
  localparam probe_t PROBE_TABLE [PROBES] = '{
    '{16'h0000, 1'b1, 16'sd700,  1'b0},   // zero sample maps to the top entry
    '{16'hffff, 1'b1, 16'sh8000, 1'b1},   // largest sample, above table
    '{16'hff41, 1'b1, 16'sh8000, 1'b1},   // just above the last breakpoint
    '{16'hff40, 1'b1, -16'sd30,  1'b0},   // last breakpoint exactly
    '{16'h4e00, 1'b1, 16'sd125,  1'b0},
    '{16'h5680, 1'b1, 16'sd120,  1'b0},
    '{16'hf440, 1'b1, 16'sd25,   1'b0},
    '{16'hf6c0, 1'b1, 16'sd20,   1'b0},
    '{16'hfcc0, 1'b1, 16'sd0,    1'b0},
    '{16'hfd80, 1'b1, -16'sd5,   1'b0},
    '{16'h0001, 1'b0, 16'sd0,    1'b0},   // widest segment, both ends
    '{16'h4dff, 1'b0, 16'sd0,    1'b0},
    '{16'h4e01, 1'b0, 16'sd0,    1'b0},
    '{16'h567f, 1'b0, 16'sd0,    1'b0},
    '{16'h5555, 1'b0, 16'sd0,    1'b0},
    '{16'haaaa, 1'b0, 16'sd0,    1'b0},
    '{16'h7fff, 1'b0, 16'sd0,    1'b0},
    '{16'h8000, 1'b0, 16'sd0,    1'b0},
    '{16'hff3f, 1'b0, 16'sd0,    1'b0},   // narrowest segments near the top
    '{16'hfec1, 1'b0, 16'sd0,    1'b0},
    '{16'h0100, 1'b0, 16'sd0,    1'b0}
  };

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic [ntcrt_pkg::S_W-1:0]        raw_sample;
  logic                             out_valid;
  logic                             out_stall;
  logic signed [ntcrt_pkg::O_W-1:0] temperature;
  logic                             over_range;

  reading_t pending_readings [$];
  reading_t offered_reading;   // expectation for the item on the input now
  int       mismatches   = 0;
  int       cycle_count  = 0;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       hold_asks    = 0;
  int       hold_served  = 0;
  int       hold_left    = 0;

  ntc_raw_to_temperature_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .raw_sample  (raw_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .temperature (temperature),
    .over_range  (over_range)
  );

  always #HALF_PERIOD clk = ~clk;

  // Find the first breakpoint not below the sample and interpolate down from
  // the breakpoint before it; the step is truncated toward zero.
  function automatic reading_t predict_temperature(logic [15:0] s);
    reading_t r;
    int       seg;
    int       offset;
    int       span;
    int       fall;
    seg = -1;
    for (int i = 0; i < KNEES; i++) begin
      if (seg < 0 && SAMPLE_KNEE[i] >= s) seg = i;
    end
    if (seg < 0) begin
      r.temperature = 16'sh8000;
      r.over_range  = 1'b1;
    end else if (seg == 0) begin
      r.temperature = 16'(DEGREE_AT[0]);
      r.over_range  = 1'b0;
    end else begin
      offset        = int'(s) - int'(SAMPLE_KNEE[seg-1]);
      span          = int'(SAMPLE_KNEE[seg]) - int'(SAMPLE_KNEE[seg-1]);
      fall          = DEGREE_AT[seg-1] - DEGREE_AT[seg];
      r.temperature = 16'(DEGREE_AT[seg-1] - (offset * fall) / span);
      r.over_range  = 1'b0;
    end
    return r;
  endfunction

  // Mix whole-range samples with breakpoints, their neighbors, the region
  // above the table, the crowded top segments and the wide first segment.
  function automatic logic [15:0] pick_sample();
    logic [15:0] s;
    int          k;
    k = $urandom_range(32, 1);
    case ($urandom_range(9))
      0, 1, 2: s = 16'($urandom);
      3: s = SAMPLE_KNEE[$urandom_range(KNEES - 1)];
      4: s = SAMPLE_KNEE[k] - 16'd1;
      5: s = SAMPLE_KNEE[k - 1] + 16'd1;
      6: s = 16'($urandom_range(16'hffff, 16'hff41));
      7: s = 16'($urandom_range(16'hff40, 16'hf000));
      8: s = 16'($urandom_range(16'h4e00, 16'h0000));
      default: s = 16'($urandom_range(SAMPLE_KNEE[k], SAMPLE_KNEE[k - 1] + 1));
    endcase
    return s;
  endfunction

  // Present one item after a random number of idle cycles and hold it
  // until the block takes it; returns at the accepting edge.
  task automatic offer_sample(logic [15:0] s, reading_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid   <= 1'b0;
      raw_sample <= 16'($urandom);
      @(negedge clk);
    end
    offered_reading = want;
    in_valid   <= 1'b1;
    raw_sample <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Drop valid and wait for every queued result to come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(int send_pct, int recv_pct);
    logic [15:0] s;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      s = pick_sample();
      offer_sample(s, predict_temperature(s));
    end
    drain_results();
  endtask

  // Receiver: stall at random, or for a long stretch when a hold-off is
  // asked for; the stretch is counted here, one cycle per falling edge.
  always @(negedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Queue the expectation of each accepted item and check each accepted
  // result against the oldest one waiting.
  always @(posedge clk) begin
    reading_t want;
    if (!rst) begin
      if (in_valid && in_stall === 1'b0) pending_readings.push_back(offered_reading);
      if (out_valid === 1'b1 && !out_stall) begin
        if (pending_readings.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: temperature %0d over_range %0b",
                   $time, temperature, over_range);
        end else begin
          want = pending_readings.pop_front();
          if (temperature !== want.temperature) begin
            mismatches++;
            $display("%0t: temperature expected %0d actual %0d",
                     $time, want.temperature, temperature);
          end
          if (over_range !== want.over_range) begin
            mismatches++;
            $display("%0t: over_range expected %0b actual %0b",
                     $time, want.over_range, over_range);
          end
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    raw_sample      = '0;
    out_stall       = 1'b0;
    offered_reading = '0;
    send_idle_pct   = 15;
    recv_idle_pct   = 71;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table with the sender mostly busy and the receiver
    // mostly stalled.
    for (int p = 0; p < PROBES; p++) begin
      if (PROBE_TABLE[p].fixed)
        offer_sample(PROBE_TABLE[p].sample,
                     '{PROBE_TABLE[p].temperature, PROBE_TABLE[p].over_range});
      else
        offer_sample(PROBE_TABLE[p].sample, predict_temperature(PROBE_TABLE[p].sample));
    end
    drain_results();

    run_random_phase(15, 71);
    run_random_phase(71, 15);

    // Hold the receiver off while the sender keeps offering at full rate,
    // so the block fills up and raises in_stall.
    hold_asks = hold_asks + 1;
    run_random_phase(0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_readings.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ ntc_raw_to_temperature_top.f @@
+incdir+src
src/ntcrt_pkg.sv
src/ntcrt_front.sv
src/ntcrt_queue.sv
src/ntcrt_back.sv
src/ntc_raw_to_temperature_top.sv
tb/sv/testbench.sv
